[src/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the escaped string scrambler
// Byte codes used by the escaper and the queue entry passed front to back.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChBackslash = 8'h5C;

  // Byte slots per entry; one input item expands to at most six bytes
  localparam int unsigned MaxBytes = 7;
  localparam int unsigned LenW     = $clog2(MaxBytes + 1);
  localparam int unsigned SlotW    = $clog2(MaxBytes);

  // One classified item: the bytes to send, in order, plus string context
  typedef struct packed {
    logic                         first;  // first entry of a new string
    logic                         mode;   // 1 = scrambled
    logic [7:0]                   key;
    logic                         term;   // final byte is the terminator
    logic [LenW-1:0]              len;    // bytes in this entry, never 0
    logic [MaxBytes-1:0][7:0]     bytes;  // slot 0 goes out first
  } esc_entry_t;

endpackage

[src/esc_fifo.sv]
// ----------------------------------------------------------------------------
// esc_fifo: small register queue
// Decouples the classifier from the byte sequencer; first-word-fall-through.
// ----------------------------------------------------------------------------
module esc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2   // 2 or more
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/esc_front.sv]
// ----------------------------------------------------------------------------
// esc_front: input classifier
// Tracks string and held-NUL state and turns each item into a byte list.
// ----------------------------------------------------------------------------
module esc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [7:0]          char_byte_i,
  input  logic                has_char_i,
  input  logic                end_of_string_i,
  input  logic [7:0]          string_key_i,
  output logic                push_o,
  output esc_pkg::esc_entry_t entry_o,
  input  logic                full_i
);

  logic in_string_q, in_string_d;
  logic nul_pend_q, nul_pend_d;
  logic start_pend_q, start_pend_d;
  logic mode_q, mode_d;
  logic [7:0] key_q, key_d;

  logic accept;
  logic pend_in;    // held NUL at entry to this item
  logic pend_mid;   // held NUL after the byte of this item
  logic first;
  logic octal;
  logic [esc_pkg::LenW-1:0] pos;
  logic [esc_pkg::MaxBytes-1:0][7:0] seq;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // A new string samples mode and key on its first item
  assign mode_d  = in_string_q ? mode_q : mode_i;
  assign key_d   = in_string_q ? key_q  : string_key_i;
  assign pend_in = in_string_q && nul_pend_q;
  assign first   = !in_string_q || start_pend_q;
  assign octal   = (char_byte_i >= esc_pkg::ChZero) && (char_byte_i <= esc_pkg::ChSeven);
  assign pend_mid = has_char_i ? (char_byte_i == esc_pkg::ChNul) : pend_in;

  // Build the byte list in output order
  always_comb begin
    seq = '0;
    pos = '0;
    if (has_char_i) begin
      if (pend_in) begin
        seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChBackslash;
        pos = pos + 1'b1;
        seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChZero;
        pos = pos + 1'b1;
        if (octal) begin
          seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChZero;
          pos = pos + 1'b1;
          seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChZero;
          pos = pos + 1'b1;
        end
      end
      if (char_byte_i == esc_pkg::ChBackslash) begin
        seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChBackslash;
        pos = pos + 1'b1;
        seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChBackslash;
        pos = pos + 1'b1;
      end else if (char_byte_i != esc_pkg::ChNul) begin
        seq[pos[esc_pkg::SlotW-1:0]] = char_byte_i;
        pos = pos + 1'b1;
      end
    end
    if (end_of_string_i) begin
      // end of string acts as a non-octal byte
      if (pend_mid) begin
        seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChBackslash;
        pos = pos + 1'b1;
        seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChZero;
        pos = pos + 1'b1;
      end
      seq[pos[esc_pkg::SlotW-1:0]] = esc_pkg::ChNul;
      pos = pos + 1'b1;
    end
  end

  assign entry_o.first = first;
  assign entry_o.mode  = mode_d;
  assign entry_o.key   = key_d;
  assign entry_o.term  = end_of_string_i;
  assign entry_o.len   = pos;
  assign entry_o.bytes = seq;

  // Items that produce nothing never enter the queue
  assign push_o = accept && (pos != '0);

  always_comb begin
    in_string_d  = in_string_q;
    nul_pend_d   = nul_pend_q;
    start_pend_d = start_pend_q;
    if (accept) begin
      in_string_d  = !end_of_string_i;
      nul_pend_d   = pend_mid && !end_of_string_i;
      start_pend_d = first && !push_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q  <= 1'b0;
      nul_pend_q   <= 1'b0;
      start_pend_q <= 1'b0;
      mode_q       <= 1'b0;
      key_q        <= '0;
    end else begin
      in_string_q  <= in_string_d;
      nul_pend_q   <= nul_pend_d;
      start_pend_q <= start_pend_d;
      if (accept) begin
        mode_q <= mode_d;
        key_q  <= key_d;
      end
    end
  end

endmodule

[src/esc_back.sv]
// ----------------------------------------------------------------------------
// esc_back: byte sequencer
// Walks the head entry one byte per cycle unless stalled, scrambles, registers out.
// ----------------------------------------------------------------------------
module esc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  esc_pkg::esc_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);

  logic [esc_pkg::SlotW-1:0] slot_q, slot_d;
  logic [8:0] idx_q, idx_d;
  logic [8:0] idx_use;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       adv;
  logic       last_slot;
  logic [7:0] raw;
  logic [7:0] mask;

  assign adv       = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_slot = ({1'b0, slot_q} == head_i.len - 1'b1);
  assign pop_o     = adv && last_slot;

  // Output index restarts at the first byte of each string
  assign idx_use = (head_i.first && (slot_q == '0)) ? '0 : idx_q;
  assign raw     = head_i.bytes[slot_q];
  assign mask    = head_i.mode ? (idx_use[8:1] + head_i.key) : '0;

  always_comb begin
    slot_d      = slot_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      slot_d      = last_slot ? '0 : slot_q + 1'b1;
      idx_d       = idx_use + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= raw ^ mask;
      out_last_q <= head_i.term && last_slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

[src/escaped_string_scrambler.sv]
// ----------------------------------------------------------------------------
// escaped_string_scrambler: string escaper with optional XOR scrambling
// NUL -> \0 or \000 (before an octal digit), backslash doubled, NUL terminator
// per string; scrambled mode XORs byte n with (n/2 + key) mod 256.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                         tuser               tlast
//  s_axis    in   [7:0] char_byte,              [0] mode,           end_of_string
//                 [15:8] string_key             [1] has_char
//  m_axis    out  [7:0] out_byte                -                   last
//
//  Cycles: the front classifies one item per cycle; the back sends one byte
//  per cycle unless stalled; an item of n bytes (n up to 6) holds the back
//  until sent. Items producing one byte or none stream at one per cycle.
//  The queue of QueueDepth entries lets the input keep going while the back
//  expands a NUL or backslash; the input stalls only when the queue is full.
//  Reset: asynchronous, active low; no clearing pass, ready right after reset.
//  Output: registered; a stalled transfer holds its byte until taken.
//
module escaped_string_scrambler #(
  parameter int unsigned QueueDepth = 2   // 2 or more
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] char_byte, [15:8] string_key
  input  logic [1:0]  s_axis_tuser_i,   // [0] mode, [1] has_char
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o    // last (terminator byte)
);

  localparam int unsigned EntryW = $bits(esc_pkg::esc_entry_t);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  esc_pkg::esc_entry_t q_in;
  esc_pkg::esc_entry_t q_head;
  logic [EntryW-1:0]   q_head_bits;

  // Front: take items, decide escape forms, build byte lists
  esc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .mode_i          (s_axis_tuser_i[0]),
    .char_byte_i     (s_axis_tdata_i[7:0]),
    .has_char_i      (s_axis_tuser_i[1]),
    .end_of_string_i (s_axis_tlast_i),
    .string_key_i    (s_axis_tdata_i[15:8]),
    .push_o          (q_push),
    .entry_o         (q_in),
    .full_i          (q_full)
  );

  esc_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head_bits)
  );

  assign q_head = esc_pkg::esc_entry_t'(q_head_bits);

  // Back: one byte per transfer, with scrambling
  esc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("push into full queue");

  // Entries in the queue always carry at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_valid |-> (q_head.len != '0))
    else $error("empty entry in queue");

  // No item expands to more than six bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_in.len != esc_pkg::LenW'(esc_pkg::MaxBytes)))
    else $error("entry too long");

  // Only a terminator entry may end with the last flag; the final byte of it is NUL
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && q_in.term |-> (q_in.bytes[q_in.len - 1'b1] == esc_pkg::ChNul))
    else $error("terminator entry without NUL");

endmodule
